FILE: sv/dsfmt_pkg.sv
// ----------------------------------------------------------------------------
// dsfmt_pkg
// Shared types, constants and register indexes of the double-precision
// twister random generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsfmt_pkg;

  // Field widths
  localparam int WORD_W      = 64;
  localparam int OUT_W       = 52;
  localparam int FILL_W      = WORD_W - OUT_W;
  localparam int SHIFT_W     = 6;
  localparam int OFFSET_W    = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 52;

  // Defaults for the top-level parameters
  localparam int STATE_ENTRIES_DEF = 192;
  localparam int RIGHT_SHIFT_A_DEF = 12;
  localparam int HIGH_FILL_DEF     = 0;

  // Seeding multiplier, split into 32-bit halves
  localparam logic [WORD_W-1:0] SEED_MULT    = 64'd6364136223846793005;
  localparam logic [31:0]       SEED_MULT_LO = SEED_MULT[31:0];
  localparam logic [31:0]       SEED_MULT_HI = SEED_MULT[63:32];

  // Register reset values
  localparam logic [OFFSET_W-1:0] PICK_OFFSET_RST   = 8'd1;
  localparam logic [SHIFT_W-1:0]  LEFT_SHIFT_B_RST  = 6'd31;
  localparam logic [SHIFT_W-1:0]  LEFT_SHIFT_C_RST  = 6'd31;
  localparam logic [SHIFT_W-1:0]  RIGHT_SHIFT_C_RST = 6'd12;
  localparam logic [WORD_W-1:0]   MASK_LOW_FULL     = 64'hedfffffbfffbffbd;
  localparam logic [WORD_W-1:0]   MASK_HIGH_FULL    = 64'haefeffd36dfdffdf;
  localparam logic [OUT_W-1:0]    MASK_LOW_RST      = MASK_LOW_FULL[OUT_W-1:0];
  localparam logic [OUT_W-1:0]    MASK_HIGH_RST     = MASK_HIGH_FULL[OUT_W-1:0];

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PICK_OFFSET   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_SHIFT_B  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_SHIFT_C  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_SHIFT_C = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_B_LOW    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_B_HIGH   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_C_LOW    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_C_HIGH   = 3'd7;

  // Operation and output mode codes
  localparam logic OP_GENERATE     = 1'b0;
  localparam logic OP_SEED         = 1'b1;
  localparam logic MODE_SAME_ENTRY = 1'b0;
  localparam logic MODE_SPLIT      = 1'b1;

  // Input item as seen on the push side
  typedef struct packed {
    logic             op;
    logic [OUT_W-1:0] seed;
    logic             out_mode;
  } item_t;

  // Result item as seen on the pop side
  typedef struct packed {
    logic [OUT_W-1:0] word_a;
    logic [OUT_W-1:0] word_b;
  } result_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic             is_seed;
    logic [OUT_W-1:0] seed;
    logic             out_mode;
  } cmd_t;

  // Queue-head status from front to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_link_t;

  // One ring entry: two 64-bit words
  typedef struct packed {
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w0;
  } entry_t;

  // Configuration register bank
  typedef struct packed {
    logic [OFFSET_W-1:0] pick_offset;
    logic [SHIFT_W-1:0]  left_shift_b;
    logic [SHIFT_W-1:0]  left_shift_c;
    logic [SHIFT_W-1:0]  right_shift_c;
    logic [OUT_W-1:0]    mask_b_low;
    logic [OUT_W-1:0]    mask_b_high;
    logic [OUT_W-1:0]    mask_c_low;
    logic [OUT_W-1:0]    mask_c_high;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/dsfmt_front.sv
// ----------------------------------------------------------------------------
// dsfmt_front
// Input side: accepts items, classifies them as seed or generate commands and
// holds them in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsfmt_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire dsfmt_pkg::item_t  item,
  output dsfmt_pkg::cmd_link_t   link,
  input  wire logic              take
);
  import dsfmt_pkg::*;

  cmd_t       slots [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;
  cmd_t       incoming;

  // Classify the incoming beat
  always_comb begin
    incoming.is_seed  = (item.op == OP_SEED);
    incoming.seed     = item.seed;
    incoming.out_mode = item.out_mode;
  end

  assign full       = (count == 2'd2);
  assign do_push    = push && !full;
  assign link.valid = (count != 2'd0);
  assign link.cmd   = slots[rd_sel];
  assign do_take    = take && link.valid;

  // Store the payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_sel] <= incoming;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_sel <= !wr_sel;
      end
      if (do_take) begin
        rd_sel <= !rd_sel;
      end
      case ({do_push, do_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/dsfmt_back.sv
// ----------------------------------------------------------------------------
// dsfmt_back
// Execution side: owns the state ring, seeds it word by word and runs the
// generate recursion, pushing one result per generate command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsfmt_back #(
  parameter int STATE_ENTRIES = dsfmt_pkg::STATE_ENTRIES_DEF,
  parameter int RIGHT_SHIFT_A = dsfmt_pkg::RIGHT_SHIFT_A_DEF,
  parameter int HIGH_FILL     = dsfmt_pkg::HIGH_FILL_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dsfmt_pkg::cfg_t      cfg,
  input  wire dsfmt_pkg::cmd_link_t link,
  output logic                      take,
  input  wire logic                 res_room,
  output logic                      res_push,
  output dsfmt_pkg::result_t        res
);
  import dsfmt_pkg::*;

  localparam int AW     = $clog2(STATE_ENTRIES);
  localparam int KW     = AW + 1;
  localparam int MOD_N  = 1 << OFFSET_W;
  localparam logic [AW-1:0] LAST_ENTRY = AW'(STATE_ENTRIES - 1);
  localparam logic [AW:0]   ENTRIES_X  = KW'(STATE_ENTRIES);
  localparam logic [KW-1:0] LAST_WORD  = KW'(2 * STATE_ENTRIES - 1);
  localparam logic [FILL_W-1:0] FILL   = FILL_W'(HIGH_FILL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GEN_DATA,
    S_GEN_EXTRA,
    S_SEED_MUL,
    S_SEED_ADD
  } state_t;

  state_t state;

  // Ring memory, two read ports with registered data
  entry_t mem [STATE_ENTRIES];
  entry_t rd_a;
  entry_t rd_b;
  logic   rd_en;
  logic   wr_en;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // Control and datapath registers
  logic [AW-1:0] ptr;
  logic          fwd_valid;
  entry_t        fwd;
  entry_t        hold_a;
  entry_t        hold_b;
  logic          mode;
  logic [WORD_W-1:0] prev_word;
  logic [WORD_W-1:0] word0;
  logic [KW-1:0]     seed_k;
  logic [WORD_W-1:0] prod_lo;
  logic [31:0]       cross_a;
  logic [31:0]       cross_b;

  // Combinational helpers
  logic [AW-1:0] mod_tbl [MOD_N];
  logic [AW:0]   pick_sum;
  logic [AW-1:0] pick_addr;
  logic [AW-1:0] next_addr;
  logic [AW-1:0] prev_addr;
  logic          need_extra;
  logic          in_extra;
  entry_t        a;
  entry_t        b;
  entry_t        c;
  entry_t        new_entry;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] mul_lo;
  logic [31:0]       mul_cross_a;
  logic [31:0]       mul_cross_b;
  logic [WORD_W-1:0] seed_sum;
  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] seed_first;

  // Offset reduction table, built at elaboration
  for (genvar i = 0; i < MOD_N; i++) begin : g_mod
    localparam int RESIDUE = i % STATE_ENTRIES;
    assign mod_tbl[i] = AW'(RESIDUE);
  end

  // Ring addresses around the pointer
  assign pick_sum  = {1'b0, ptr} + {1'b0, mod_tbl[cfg.pick_offset]};
  assign pick_addr = (pick_sum >= ENTRIES_X) ? AW'(pick_sum - ENTRIES_X) : pick_sum[AW-1:0];
  assign next_addr = (ptr == LAST_ENTRY) ? '0 : ptr + AW'(1);
  assign prev_addr = (ptr == '0) ? LAST_ENTRY : ptr - AW'(1);

  // Select recursion operands: extra pass brings the previous entry from memory
  assign need_extra = (mode == MODE_SPLIT) || !fwd_valid;
  assign in_extra   = (state == S_GEN_EXTRA);
  assign a = in_extra ? hold_a : rd_a;
  assign b = in_extra ? hold_b : rd_b;
  assign c = in_extra ? rd_a   : fwd;

  // Entry recursion
  always_comb begin
    new_entry.w0 = a.w1 ^ (a.w0 >> RIGHT_SHIFT_A)
                 ^ ((b.w0 ^ (b.w0 << cfg.left_shift_b)) & WORD_W'(cfg.mask_b_low))
                 ^ (c.w0 >> cfg.right_shift_c)
                 ^ ((c.w0 << cfg.left_shift_c) & WORD_W'(cfg.mask_c_low));
    new_entry.w1 = a.w0 ^ (a.w1 >> RIGHT_SHIFT_A)
                 ^ ((b.w1 ^ (b.w1 << cfg.left_shift_b)) & WORD_W'(cfg.mask_b_high))
                 ^ (c.w1 >> cfg.right_shift_c)
                 ^ ((c.w1 << cfg.left_shift_c) & WORD_W'(cfg.mask_c_high));
  end

  // Result words, read before the entry is rewritten
  assign res.word_a = (mode == MODE_SPLIT) ? a.w1[OUT_W-1:0] : a.w0[OUT_W-1:0];
  assign res.word_b = (mode == MODE_SPLIT) ? rd_b.w0[OUT_W-1:0] : a.w1[OUT_W-1:0];

  // Seeding chain: split 64-bit multiply, then sum and fill
  assign mix         = prev_word ^ (prev_word >> 62);
  assign mul_lo      = mix[31:0] * SEED_MULT_LO;
  assign mul_cross_a = 32'(mix[63:32] * SEED_MULT_LO);
  assign mul_cross_b = 32'(mix[31:0] * SEED_MULT_HI);
  assign seed_sum    = prod_lo + {cross_a + cross_b, 32'b0} + WORD_W'(seed_k);
  assign seed_word   = {FILL, seed_sum[OUT_W-1:0]};
  assign seed_first  = {FILL, link.cmd.seed};

  // Drive memory ports, queue take and result push
  always_comb begin
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    addr_a   = ptr;
    addr_b   = pick_addr;
    wr_addr  = ptr;
    wr_data  = new_entry;
    take     = 1'b0;
    res_push = 1'b0;
    case (state)
      S_IDLE: begin
        if (link.valid && (link.cmd.is_seed || res_room)) begin
          take  = 1'b1;
          rd_en = !link.cmd.is_seed;
        end
      end
      S_GEN_DATA: begin
        if (need_extra) begin
          rd_en  = 1'b1;
          addr_a = prev_addr;
          addr_b = next_addr;
        end else begin
          wr_en    = 1'b1;
          res_push = 1'b1;
        end
      end
      S_GEN_EXTRA: begin
        wr_en    = 1'b1;
        res_push = 1'b1;
      end
      S_SEED_ADD: begin
        wr_en   = seed_k[0];
        wr_addr = seed_k[KW-1:1];
        wr_data = {seed_word, word0};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Ring memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      fwd_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            if (link.cmd.is_seed) begin
              prev_word <= seed_first;
              word0     <= seed_first;
              seed_k    <= KW'(1);
              state     <= S_SEED_MUL;
            end else begin
              mode  <= link.cmd.out_mode;
              state <= S_GEN_DATA;
            end
          end
        end
        S_GEN_DATA: begin
          if (need_extra) begin
            hold_a <= rd_a;
            hold_b <= rd_b;
            state  <= S_GEN_EXTRA;
          end else begin
            fwd       <= new_entry;
            fwd_valid <= 1'b1;
            ptr       <= next_addr;
            state     <= S_IDLE;
          end
        end
        S_GEN_EXTRA: begin
          fwd       <= new_entry;
          fwd_valid <= 1'b1;
          ptr       <= next_addr;
          state     <= S_IDLE;
        end
        S_SEED_MUL: begin
          prod_lo <= mul_lo;
          cross_a <= mul_cross_a;
          cross_b <= mul_cross_b;
          state   <= S_SEED_ADD;
        end
        S_SEED_ADD: begin
          prev_word <= seed_word;
          if (!seed_k[0]) begin
            word0 <= seed_word;
          end
          if (seed_k == LAST_WORD) begin
            ptr       <= '0;
            fwd_valid <= 1'b0;
            state     <= S_IDLE;
          end else begin
            seed_k <= seed_k + KW'(1);
            state  <= S_SEED_MUL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/dsfmt_res_queue.sv
// ----------------------------------------------------------------------------
// dsfmt_res_queue
// Two-entry result queue between the back end and the pop side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsfmt_res_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_push,
  input  wire dsfmt_pkg::result_t  in_res,
  output logic                     room,
  output logic                     empty,
  input  wire logic                pop,
  output dsfmt_pkg::result_t       result
);
  import dsfmt_pkg::*;

  result_t    slots [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] count;
  logic       do_pop;

  assign room   = (count != 2'd2);
  assign empty  = (count == 2'd0);
  assign result = slots[rd_sel];
  assign do_pop = pop && !empty;

  // Store the result beat
  always_ff @(posedge clk) begin
    if (in_push) begin
      slots[wr_sel] <= in_res;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_push) begin
        wr_sel <= !wr_sel;
      end
      if (do_pop) begin
        rd_sel <= !rd_sel;
      end
      case ({in_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/dsfmt_prng_generator_unit.sv
// ----------------------------------------------------------------------------
// dsfmt_prng_generator_unit
// Double-precision twister random generator with queue-style ports.
// ----------------------------------------------------------------------------
// Items enter through a two-entry command queue and results leave through a
// two-entry result queue; the state ring is a memory of STATE_ENTRIES 128-bit
// entries with two registered read ports and one write port, and it has no
// reset, so seed the block before the first generate item. In the back end
// a generate item reads the current and pick entries, then updates and
// writes, with the previous entry forwarded from the last write; it takes an
// extra pass when out_mode is 1 or when it is the first generate after
// seeding, since the next or previous entry then needs a second ring read.
// A seed item runs the fill chain, in which every 64-bit word after the
// first passes through the split multiply and then the sum. Write the
// configuration registers only while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsfmt_prng_generator_unit #(
  parameter int STATE_ENTRIES = dsfmt_pkg::STATE_ENTRIES_DEF,
  parameter int RIGHT_SHIFT_A = dsfmt_pkg::RIGHT_SHIFT_A_DEF,
  parameter int HIGH_FILL     = dsfmt_pkg::HIGH_FILL_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   push,
  output logic                                        full,
  input  wire dsfmt_pkg::item_t                       item,
  output logic                                        empty,
  input  wire logic                                   pop,
  output dsfmt_pkg::result_t                          result,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [dsfmt_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [dsfmt_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dsfmt_pkg::*;

  cfg_t      cfg;
  cmd_link_t link;
  logic      take;
  logic      res_room;
  logic      res_push;
  result_t   res;

  assign cfg_ready = 1'b1;

  // Configuration register bank
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pick_offset   <= PICK_OFFSET_RST;
      cfg.left_shift_b  <= LEFT_SHIFT_B_RST;
      cfg.left_shift_c  <= LEFT_SHIFT_C_RST;
      cfg.right_shift_c <= RIGHT_SHIFT_C_RST;
      cfg.mask_b_low    <= MASK_LOW_RST;
      cfg.mask_b_high   <= MASK_HIGH_RST;
      cfg.mask_c_low    <= MASK_LOW_RST;
      cfg.mask_c_high   <= MASK_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PICK_OFFSET:   cfg.pick_offset   <= cfg_data[OFFSET_W-1:0];
        REG_LEFT_SHIFT_B:  cfg.left_shift_b  <= cfg_data[SHIFT_W-1:0];
        REG_LEFT_SHIFT_C:  cfg.left_shift_c  <= cfg_data[SHIFT_W-1:0];
        REG_RIGHT_SHIFT_C: cfg.right_shift_c <= cfg_data[SHIFT_W-1:0];
        REG_MASK_B_LOW:    cfg.mask_b_low    <= cfg_data[OUT_W-1:0];
        REG_MASK_B_HIGH:   cfg.mask_b_high   <= cfg_data[OUT_W-1:0];
        REG_MASK_C_LOW:    cfg.mask_c_low    <= cfg_data[OUT_W-1:0];
        REG_MASK_C_HIGH:   cfg.mask_c_high   <= cfg_data[OUT_W-1:0];
        default:           cfg.pick_offset   <= cfg.pick_offset;
      endcase
    end
  end

  dsfmt_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .item (item),
    .link (link),
    .take (take)
  );

  dsfmt_back #(
    .STATE_ENTRIES (STATE_ENTRIES),
    .RIGHT_SHIFT_A (RIGHT_SHIFT_A),
    .HIGH_FILL     (HIGH_FILL)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .link     (link),
    .take     (take),
    .res_room (res_room),
    .res_push (res_push),
    .res      (res)
  );

  dsfmt_res_queue u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .in_push (res_push),
    .in_res  (res),
    .room    (res_room),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

FILE: sv/dsfmt_checker.sv
// ----------------------------------------------------------------------------
// dsfmt_checker
// Port-level checks of the generator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsfmt_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               push,
  input wire logic                               full,
  input wire dsfmt_pkg::item_t                   item,
  input wire logic                               empty,
  input wire logic                               pop,
  input wire dsfmt_pkg::result_t                 result,
  input wire logic                               cfg_valid,
  input wire logic                               cfg_ready,
  input wire logic [dsfmt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input wire logic [dsfmt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Reset drains both queues
  a_reset_drains: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not drained after reset");

  // The command queue fills only through an accepted push beat
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    !push |=> !$rose(full))
    else $error("full rose without a push beat");

  // A waiting result stays put until popped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed or vanished");

  // The configuration channel never stalls
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind dsfmt_prng_generator_unit dsfmt_checker u_checker (.*);

`default_nettype wire
